### sv/apbq_pkg.sv
package apbq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 25;
    localparam int COEF_FRAC_BITS = 22;
    localparam int STAGE_BITS     = 8;
    localparam int CFG_DATA_BITS  = 25;
    localparam int CFG_INDEX_BITS = 3;

    // Product of a coefficient and a sample, and the section accumulator
    // (four products plus the shifted x2 term, with headroom).
    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_B0_CH1     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B1_CH1     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B0_CH2     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B1_CH2     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGES_CH1 = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STAGES_CH2 = 3'd5;

    localparam logic [STAGE_BITS-1:0] STAGES_RESET = 8'd4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    typedef struct packed {
        sample_t sample_ch1;
        sample_t sample_ch2;
    } in_item_t;

    typedef struct packed {
        sample_t out_ch1;
        sample_t out_ch2;
    } out_item_t;

    // One section's history, kept as one memory word.
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } hist_entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

### sv/apbq_hist_mem.sv
module apbq_hist_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  apbq_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  apbq_pkg::hist_entry_t wr_data,
    output apbq_pkg::hist_entry_t rd_data
);
    import apbq_pkg::*;

    hist_entry_t mem [DEPTH];
    hist_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/apbq_section_dp.sv
module apbq_section_dp (
    input  logic                  clk,
    input  logic                  mul_en,
    input  apbq_pkg::sample_t     x,
    input  apbq_pkg::coef_t       b0,
    input  apbq_pkg::coef_t       b1,
    input  apbq_pkg::hist_entry_t hist,
    output apbq_pkg::sample_t     y,
    output apbq_pkg::sample_t     hx1,
    output apbq_pkg::sample_t     hy1
);
    import apbq_pkg::*;

    localparam logic signed [ACC_BITS-1:0] RND  = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] SMAX = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SMIN = -SMAX - ACC_BITS'(1);

    logic signed [PROD_BITS-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PROD_BITS-1:0] p0_next, p1_next, p2_next, p3_next;
    sample_t x2_reg, x1_reg, y1_reg;

    logic signed [ACC_BITS-1:0] acc;
    logic signed [ACC_BITS-1:0] shifted;

    // Multiply stage: all four products at once, history comes straight from memory.
    always_comb
    begin
        p0_next = b0 * x;
        p1_next = b1 * hist.x1;
        p2_next = b1 * hist.y1;
        p3_next = b0 * hist.y2;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            x2_reg <= hist.x2;
            x1_reg <= hist.x1;
            y1_reg <= hist.y1;
        end
    end

    // Sum, round half up, saturate.
    always_comb
    begin
        acc = ACC_BITS'(p0_reg) + ACC_BITS'(p1_reg)
            + (ACC_BITS'(x2_reg) <<< COEF_FRAC_BITS)
            - ACC_BITS'(p2_reg) - ACC_BITS'(p3_reg) + RND;
        shifted = acc >>> COEF_FRAC_BITS;
        if (shifted > SMAX)
        begin
            y = SMAX[SAMPLE_BITS-1:0];
        end
        else if (shifted < SMIN)
        begin
            y = SMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign hx1 = x1_reg;
    assign hy1 = y1_reg;

endmodule

### sv/apbq_seq.sv
module apbq_seq #(
    parameter int MAX_STAGES = 128,
    parameter int AW         = 8,
    parameter int SW         = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  apbq_pkg::in_item_t              sample,
    input  logic [apbq_pkg::STAGE_BITS-1:0] stages_ch1,
    input  logic [apbq_pkg::STAGE_BITS-1:0] stages_ch2,
    input  logic                            out_free,
    output logic                            done,
    output apbq_pkg::out_item_t             done_item,
    output logic                            ch,
    output logic                            mul_en,
    output apbq_pkg::sample_t               x,
    input  apbq_pkg::sample_t               y,
    input  apbq_pkg::sample_t               hx1,
    input  apbq_pkg::sample_t               hy1,
    output apbq_pkg::mem_ctl_t              mem_ctl,
    output logic [AW-1:0]                   rd_addr,
    output logic [AW-1:0]                   wr_addr,
    output apbq_pkg::hist_entry_t           wr_data
);
    import apbq_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SETUP = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_ACC   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    localparam logic [AW-1:0] LAST_ADDR = AW'(2 * MAX_STAGES - 1);

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           ch_reg, ch_next;
    logic [SW-1:0]  sec_reg, sec_next;
    logic [SW-1:0]  n_reg, n_next;
    sample_t        x_reg, x_next;
    sample_t        hold_reg, hold_next;
    sample_t        res1_reg, res1_next;

    logic [STAGE_BITS-1:0] stages_sel;
    logic [SW-1:0]         n_sel;
    logic [SW-1:0]         sec_inc;

    function automatic logic [AW-1:0] hist_addr(input logic c, input logic [SW-1:0] s);
        return AW'(s) + (c ? AW'(MAX_STAGES) : AW'(0));
    endfunction

    always_comb
    begin
        stages_sel = ch_reg ? stages_ch2 : stages_ch1;
        n_sel = (32'(stages_sel) > MAX_STAGES) ? SW'(MAX_STAGES) : SW'(stages_sel);
        sec_inc = sec_reg + SW'(1);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ch_next      = ch_reg;
        sec_next     = sec_reg;
        n_next       = n_reg;
        x_next       = x_reg;
        hold_next    = hold_reg;
        res1_next    = res1_reg;
        mem_ctl      = '0;
        mul_en       = 1'b0;
        done         = 1'b0;
        rd_addr      = hist_addr(ch_reg, '0);
        wr_addr      = hist_addr(ch_reg, sec_reg);
        wr_data      = '{x1: x_reg, x2: hx1, y1: y, y2: hy1};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = clr_cnt_reg;
                wr_data       = '0;
                clr_cnt_next  = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    x_next     = sample.sample_ch1;
                    hold_next  = sample.sample_ch2;
                    ch_next    = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                sec_next = '0;
                n_next   = n_sel;
                if (n_sel == '0)
                begin
                    // pass the sample through untouched
                    if (!ch_reg)
                    begin
                        res1_next = x_reg;
                        x_next    = hold_reg;
                        ch_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                mem_ctl.wr_en = 1'b1;
                if (sec_inc < n_reg)
                begin
                    x_next        = y;
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = hist_addr(ch_reg, sec_inc);
                    sec_next      = sec_inc;
                    state_next    = ST_MUL;
                end
                else if (!ch_reg)
                begin
                    res1_next  = y;
                    x_next     = hold_reg;
                    ch_next    = 1'b1;
                    state_next = ST_SETUP;
                end
                else
                begin
                    x_next     = y;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ch_reg      <= 1'b0;
            sec_reg     <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ch_reg      <= ch_next;
            sec_reg     <= sec_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        hold_reg <= hold_next;
        res1_reg <= res1_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign done_item    = '{out_ch1: res1_reg, out_ch2: x_reg};
    assign ch           = ch_reg;
    assign x            = x_reg;

endmodule

### sv/allpass_biquad_cascade.sv
// Two-channel cascade of second-order allpass sections (phaser core). Each
// beat on the sample channel carries one sample per channel; each channel runs
// through its own first stages_chN sections (clamped to MAX_STAGES), and one
// result beat follows. Section history lives in one single-port-read,
// single-port-write memory of 2*MAX_STAGES words. Each section runs through a
// multiply state, then a sum/round/saturate and write-back state. After reset
// the block zeroes all 2*MAX_STAGES history words and holds sample_stall high
// meanwhile; configuration writes are taken at any time but belong in idle
// periods. A finished result waits in an output register, so the next sample
// beat is taken while it is still stalled.
module allpass_biquad_cascade #(
    parameter int MAX_STAGES = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  apbq_pkg::in_item_t                  sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output apbq_pkg::out_item_t                 result,
    input  logic                                cfg_we,
    input  logic [apbq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [apbq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import apbq_pkg::*;

    localparam int DEPTH = 2 * MAX_STAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_STAGES > 0) ? $clog2(MAX_STAGES + 1) : 1;

    coef_t                 b0_ch1_reg, b1_ch1_reg, b0_ch2_reg, b1_ch2_reg;
    logic [STAGE_BITS-1:0] stages_ch1_reg, stages_ch2_reg;

    logic        result_valid_reg;
    out_item_t   result_reg;

    logic        out_free;
    logic        done;
    out_item_t   done_item;
    logic        ch;
    logic        mul_en;
    sample_t     x, y, hx1, hy1;
    mem_ctl_t    mem_ctl;
    logic [AW-1:0] rd_addr, wr_addr;
    hist_entry_t wr_data, rd_data;
    coef_t       b0_sel, b1_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_ch1_reg     <= '0;
            b1_ch1_reg     <= '0;
            b0_ch2_reg     <= '0;
            b1_ch2_reg     <= '0;
            stages_ch1_reg <= STAGES_RESET;
            stages_ch2_reg <= STAGES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B0_CH1:     b0_ch1_reg     <= cfg_data[COEF_BITS-1:0];
                REG_B1_CH1:     b1_ch1_reg     <= cfg_data[COEF_BITS-1:0];
                REG_B0_CH2:     b0_ch2_reg     <= cfg_data[COEF_BITS-1:0];
                REG_B1_CH2:     b1_ch2_reg     <= cfg_data[COEF_BITS-1:0];
                REG_STAGES_CH1: stages_ch1_reg <= cfg_data[STAGE_BITS-1:0];
                REG_STAGES_CH2: stages_ch2_reg <= cfg_data[STAGE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign b0_sel   = ch ? b0_ch2_reg : b0_ch1_reg;
    assign b1_sel   = ch ? b1_ch2_reg : b1_ch1_reg;
    assign out_free = !result_valid_reg || !result_stall;

    apbq_seq #(
        .MAX_STAGES (MAX_STAGES),
        .AW         (AW),
        .SW         (SW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .stages_ch1   (stages_ch1_reg),
        .stages_ch2   (stages_ch2_reg),
        .out_free     (out_free),
        .done         (done),
        .done_item    (done_item),
        .ch           (ch),
        .mul_en       (mul_en),
        .x            (x),
        .y            (y),
        .hx1          (hx1),
        .hy1          (hy1),
        .mem_ctl      (mem_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    apbq_hist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_hist_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    apbq_section_dp u_section_dp (
        .clk    (clk),
        .mul_en (mul_en),
        .x      (x),
        .b0     (b0_sel),
        .b1     (b1_sel),
        .hist   (rd_data),
        .y      (y),
        .hx1    (hx1),
        .hy1    (hy1)
    );

    // Output register: load a finished beat, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg <= done_item;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apbq_pkg::*;

    localparam int SECTIONS_MAX = 128;
    localparam int HIST_WORDS   = 2 * SECTIONS_MAX;
    localparam longint SAT_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO   = -SAT_HI - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);

    localparam sample_t S_MAX = 24'sh7FFFFF;
    localparam sample_t S_MIN = 24'sh800000;
    localparam coef_t   C_MAX = 25'sh0FFFFFF;
    localparam coef_t   C_MIN = 25'sh1000000;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    localparam longint RUN_LIMIT_NS = 5_000_000;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        in_item_t                  item;
        bit                        pinned;
        out_item_t                 want;
    } plan_row_t;

    typedef struct {
        out_item_t val;
        int        seq;
    } pending_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    in_item_t                  sample = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    out_item_t                 result;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Local copy of the block's registers and section history
    coef_t            b0_ch1 = '0;
    coef_t            b1_ch1 = '0;
    coef_t            b0_ch2 = '0;
    coef_t            b1_ch2 = '0;
    logic [STAGE_BITS-1:0] stages_ch1 = STAGES_RESET;
    logic [STAGE_BITS-1:0] stages_ch2 = STAGES_RESET;
    sample_t          sec_x1 [HIST_WORDS];
    sample_t          sec_x2 [HIST_WORDS];
    sample_t          sec_y1 [HIST_WORDS];
    sample_t          sec_y2 [HIST_WORDS];

    pending_beat_t    filtered_pending [$];
    plan_row_t        directed_plan [$];
    int               n_taken = 0;
    int               n_errors = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               pinned_on = 1'b0;
    out_item_t        pinned_out = '0;

    allpass_biquad_cascade #(.MAX_STAGES(SECTIONS_MAX)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_B0_CH1:     b0_ch1 = coef_t'(data);
            REG_B1_CH1:     b1_ch1 = coef_t'(data);
            REG_B0_CH2:     b0_ch2 = coef_t'(data);
            REG_B1_CH2:     b1_ch2 = coef_t'(data);
            REG_STAGES_CH1: stages_ch1 = data[STAGE_BITS-1:0];
            REG_STAGES_CH2: stages_ch2 = data[STAGE_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Run one channel's sample through its sections, updating their history.
    function automatic sample_t allpass_cascade(sample_t x_in, coef_t b0, coef_t b1,
                                                logic [STAGE_BITS-1:0] n_raw, int ch);
        longint acc;
        longint x;
        int     n;
        int     k;
        n = int'(n_raw);
        if (n > SECTIONS_MAX)
            n = SECTIONS_MAX;
        x = longint'(x_in);
        for (int s = 0; s < n; s++)
        begin
            k = ch * SECTIONS_MAX + s;
            acc = longint'(b0) * x
                + longint'(b1) * longint'(sec_x1[k])
                + (longint'(sec_x2[k]) <<< COEF_FRAC_BITS)
                - longint'(b1) * longint'(sec_y1[k])
                - longint'(b0) * longint'(sec_y2[k]);
            acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
            if (acc > SAT_HI)
                acc = SAT_HI;
            else if (acc < SAT_LO)
                acc = SAT_LO;
            sec_x2[k] = sec_x1[k];
            sec_y2[k] = sec_y1[k];
            sec_x1[k] = sample_t'(x);
            sec_y1[k] = sample_t'(acc);
            x = acc;
        end
        return sample_t'(x);
    endfunction

    always @(posedge clk)
    begin : watch
        out_item_t     calc;
        pending_beat_t head;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (filtered_pending.size() == 0)
                    report_mismatch($sformatf("result beat with nothing pending: %0d %0d",
                                              result.out_ch1, result.out_ch2));
                else
                begin
                    head = filtered_pending.pop_front();
                    if (result.out_ch1 !== head.val.out_ch1)
                        report_mismatch($sformatf("beat %0d out_ch1: got %0d, want %0d",
                                                  head.seq, result.out_ch1,
                                                  head.val.out_ch1));
                    if (result.out_ch2 !== head.val.out_ch2)
                        report_mismatch($sformatf("beat %0d out_ch2: got %0d, want %0d",
                                                  head.seq, result.out_ch2,
                                                  head.val.out_ch2));
                end
            end
            if (sample_valid && !sample_stall)
            begin
                calc.out_ch1 = allpass_cascade(sample.sample_ch1, b0_ch1, b1_ch1,
                                               stages_ch1, 0);
                calc.out_ch2 = allpass_cascade(sample.sample_ch2, b0_ch2, b1_ch2,
                                               stages_ch2, 1);
                if (pinned_on)
                    calc = pinned_out;
                filtered_pending.push_back('{val: calc, seq: n_taken});
                n_taken++;
            end
            if (cfg_we)
                apply_reg(cfg_index, cfg_data);
        end
    end

    // Enter and leave at a falling edge; drop valid once the beat is taken.
    task automatic send_item(in_item_t it, bit pin, out_item_t want);
        int target;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        pinned_on = pin;
        pinned_out = want;
        sample_valid <= 1'b1;
        sample <= it;
        target = n_taken + 1;
        do
            @(negedge clk);
        while (n_taken != target);
        sample_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every result beat has come back.
    task automatic settle();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (filtered_pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic void add_cfg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
        plan_row_t r;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        r.item = '0;
        r.pinned = 1'b0;
        r.want = '0;
        directed_plan.push_back(r);
    endfunction

    function automatic void add_item(sample_t a, sample_t b, bit pin = 1'b0,
                                     sample_t wa = '0, sample_t wb = '0);
        plan_row_t r;
        r.kind = ROW_ITEM;
        r.idx = '0;
        r.data = '0;
        r.item.sample_ch1 = a;
        r.item.sample_ch2 = b;
        r.pinned = pin;
        r.want.out_ch1 = wa;
        r.want.out_ch2 = wb;
        directed_plan.push_back(r);
    endfunction

    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return sample_t'($urandom());
        if (pick < 85)
            return sample_t'(int'($urandom_range(8191)) - 4096);
        return (pick % 2 == 0) ? S_MAX : S_MIN;
    endfunction

    function automatic logic [STAGE_BITS-1:0] random_stages();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return STAGE_BITS'($urandom_range(255, 128));
        return STAGE_BITS'($urandom_range(8, 1));
    endfunction

    // Mostly stable allpass coefficients, now and then any 25-bit value.
    task automatic random_setting();
        logic [CFG_DATA_BITS-1:0] upper;
        for (int ch = 0; ch < 2; ch++)
        begin
            if ($urandom_range(3) != 0)
            begin
                write_reg(ch == 0 ? REG_B0_CH1 : REG_B0_CH2,
                          CFG_DATA_BITS'(int'($urandom_range(8388606)) - 4194303));
                write_reg(ch == 0 ? REG_B1_CH1 : REG_B1_CH2,
                          CFG_DATA_BITS'(int'($urandom_range(16777216)) - 8388608));
            end
            else
            begin
                write_reg(ch == 0 ? REG_B0_CH1 : REG_B0_CH2, CFG_DATA_BITS'($urandom()));
                write_reg(ch == 0 ? REG_B1_CH1 : REG_B1_CH2, CFG_DATA_BITS'($urandom()));
            end
            // upper data bits are don't-care for the stage counts
            upper = CFG_DATA_BITS'($urandom());
            write_reg(ch == 0 ? REG_STAGES_CH1 : REG_STAGES_CH2,
                      {upper[CFG_DATA_BITS-1:STAGE_BITS], random_stages()});
        end
    endtask

    initial
    begin : run
        in_item_t it;
        for (int k = 0; k < HIST_WORDS; k++)
        begin
            sec_x1[k] = '0;
            sec_x2[k] = '0;
            sec_y1[k] = '0;
            sec_y2[k] = '0;
        end

        // after reset: zero coefficients make each section a two-sample delay
        add_item(S_MAX, S_MIN, 1'b1, '0, '0);
        add_item(-1, 1, 1'b1, '0, '0);
        // zero stages: straight pass-through
        add_cfg(REG_STAGES_CH1, '0);
        add_cfg(REG_STAGES_CH2, '0);
        add_item(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
        add_item(0, -1, 1'b1, 0, -1);
        add_item(S_MIN, S_MAX, 1'b1, S_MIN, S_MAX);
        // extreme coefficients, count above the maximum on channel two
        add_cfg(REG_B0_CH1, C_MAX);
        add_cfg(REG_B1_CH1, C_MIN);
        add_cfg(REG_B0_CH2, C_MIN);
        add_cfg(REG_B1_CH2, C_MAX);
        add_cfg(REG_STAGES_CH1, 1);
        add_cfg(REG_STAGES_CH2, 255);
        add_item(S_MAX, S_MAX);
        add_item(S_MIN, S_MIN);
        add_item(S_MAX, S_MIN);
        add_item(0, 0);
        add_item(-1, -1);
        // writes to unused indexes must change nothing
        add_cfg(REG_SPARE_6, '1);
        add_cfg(REG_SPARE_7, 25'h0AAAAAA);
        add_cfg(REG_STAGES_CH1, 128);
        add_cfg(REG_STAGES_CH2, 0);
        add_item(S_MIN, S_MAX);
        add_item(12345, -12345);
        add_item(S_MAX, 0);
        add_cfg(REG_B0_CH1, 2097152);
        add_cfg(REG_B1_CH1, -6291456);
        add_cfg(REG_B0_CH2, -2097152);
        add_cfg(REG_B1_CH2, 6291456);
        add_cfg(REG_STAGES_CH1, 4);
        add_cfg(REG_STAGES_CH2, 129);
        add_item(S_MAX, S_MAX);
        add_item(0, 0);
        add_item(0, 0);
        add_item(-4194304, 4194304);
        add_item(S_MIN, S_MIN);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 46;
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed_plan[i].idx, directed_plan[i].data);
            end
            else
                send_item(directed_plan[i].item, directed_plan[i].pinned,
                          directed_plan[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 19 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                settle();
                random_setting();
                repeat (42)
                begin
                    it.sample_ch1 = random_sample();
                    it.sample_ch2 = random_sample();
                    send_item(it, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (n_errors == 0)
            $display("PASS allpass_biquad_cascade");
        else
            $display("FAIL allpass_biquad_cascade");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL allpass_biquad_cascade");
        $finish;
    end

endmodule

### allpass_biquad_cascade.f
sv/apbq_pkg.sv
sv/apbq_hist_mem.sv
sv/apbq_section_dp.sv
sv/apbq_seq.sv
sv/allpass_biquad_cascade.sv
bench/tb_top.sv
